// ----- src/ipcmb_pkg.sv -----
// Package with types, codes and default sizes for the IPC port mailbox scheduler.
package ipcmb_pkg;

   localparam int DEF_NUM_PORTS   = 64;
   localparam int DEF_QUEUE_DEPTH = 32;
   localparam int DEF_NUM_PROCS   = 256;

   localparam logic [2:0] OP_SEND   = 3'd0;
   localparam logic [2:0] OP_RECV   = 3'd1;
   localparam logic [2:0] OP_CREATE = 3'd2;
   localparam logic [2:0] OP_YIELD  = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;

   localparam logic [2:0] STS_OK      = 3'd0;
   localparam logic [2:0] STS_NOPORT  = 3'd1;
   localparam logic [2:0] STS_FULL    = 3'd2;
   localparam logic [2:0] STS_EMPTY   = 3'd3;
   localparam logic [2:0] STS_BLOCKED = 3'd4;
   localparam logic [2:0] STS_NOFREE  = 3'd5;
   localparam logic [2:0] STS_IDLE    = 3'd6;
   localparam logic [2:0] STS_BADOP   = 3'd7;

   localparam logic [1:0] PS_READY   = 2'd0;
   localparam logic [1:0] PS_RUNNING = 2'd1;
   localparam logic [1:0] PS_BLOCKED = 2'd2;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_PSCAN,
      SEQ_PEVAL,
      SEQ_QRD,
      SEQ_PRD,
      SEQ_PCHK,
      SEQ_SSCAN,
      SEQ_DONE,
      SEQ_CLEAR
   } seq_state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] port_id;
      logic [31:0] msg_handle;
      logic        blocking;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] new_port_id;
      logic [31:0] msg_out;
      logic [7:0]  running_pid;
   } rsp_type;

endpackage

// ----- src/ipc_port_mailbox_scheduler.sv -----
// Top level of the IPC port mailbox and round-robin process scheduler.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data  (op, port_id, msg_handle, blocking)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (status, new_port_id, msg_out,
//           |           |                      |            running_pid)
//
// A request runs alone through a small sequencer. Send, receive and create scan the port
// table one entry per cycle; yield and tick scan the process table one entry per cycle.
// A blocking receive on an empty port does both scans.
// After reset a clearing pass writes every process table entry with req_stall high;
// port table entries that were never created read as zero through their valid bits.
// A new request is taken while a finished result waits behind rsp_stall.
module ipc_port_mailbox_scheduler #(
   parameter int NUM_PORTS   = ipcmb_pkg::DEF_NUM_PORTS,
   parameter int QUEUE_DEPTH = ipcmb_pkg::DEF_QUEUE_DEPTH,
   parameter int NUM_PROCS   = ipcmb_pkg::DEF_NUM_PROCS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ipcmb_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ipcmb_pkg::rsp_type rsp_data
);
   import ipcmb_pkg::*;

   localparam int PIW = $clog2(NUM_PORTS);
   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int PW  = $clog2(NUM_PROCS);
   localparam int QAW = $clog2(NUM_PORTS * QUEUE_DEPTH);

   // Storage.
   logic [PW-1:0]  owner_mem [NUM_PORTS];
   logic [31:0]    ident_mem [NUM_PORTS];
   logic [QW-1:0]  head_mem  [NUM_PORTS];
   logic [QW-1:0]  tail_mem  [NUM_PORTS];
   logic [31:0]    queue_mem [NUM_PORTS * QUEUE_DEPTH];
   logic [1:0]     pstate_mem[NUM_PROCS];
   logic [31:0]    pwait_mem [NUM_PROCS];
   logic [NUM_PORTS-1:0] port_vld_ff;

   // Control and working registers.
   seq_state_type  state_ff, state_in;
   logic [PW-1:0]  clr_ff, clr_in;
   logic [2:0]     op_ff, op_in;
   logic [31:0]    pid_ff, pid_in;
   logic [31:0]    hdl_ff, hdl_in;
   logic           blk_ff, blk_in;
   logic [PW-1:0]  cur_ff, cur_in;
   logic [31:0]    nid_ff, nid_in;
   logic [PIW:0]   scan_ff, scan_in;
   logic           prd_ok_ff, prd_ok_in;
   logic           prd_last_ff, prd_last_in;
   logic [PIW-1:0] prd_idx_ff, prd_idx_in;
   logic [PW-1:0]  prd_owner_ff;
   logic [31:0]    prd_ident_ff;
   logic [QW-1:0]  prd_head_ff;
   logic [QW-1:0]  prd_tail_ff;
   logic [PIW-1:0] fidx_ff, fidx_in;
   logic [PW-1:0]  fowner_ff, fowner_in;
   logic [QW-1:0]  fhead_ff, fhead_in;
   logic [QW-1:0]  ftail_ff, ftail_in;
   logic [PW-1:0]  sch_addr_ff, sch_addr_in;
   logic [PW:0]    sch_cnt_ff, sch_cnt_in;
   logic           srd_ok_ff, srd_ok_in;
   logic           srd_last_ff, srd_last_in;
   logic [PW-1:0]  srd_idx_ff, srd_idx_in;
   logic [1:0]     ps_rd_ff;
   logic [31:0]    pw_rd_ff;
   logic [31:0]    q_rd_ff;
   logic [2:0]     res_sts_ff, res_sts_in;
   logic [31:0]    res_nid_ff, res_nid_in;
   logic [31:0]    res_msg_ff, res_msg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   // Memory port controls.
   logic [PIW-1:0] port_raddr;
   logic [PIW-1:0] port_waddr;
   logic           port_create;
   logic           head_we;
   logic           tail_we;
   logic [QW-1:0]  queue_ptr_wdata;
   logic [QAW-1:0] q_addr;
   logic           q_we;
   logic [PW-1:0]  proc_raddr;
   logic [PW-1:0]  ps_waddr;
   logic           ps_we;
   logic [1:0]     ps_wdata;
   logic           pw_we;
   logic [PW-1:0]  pw_waddr;
   logic [31:0]    pw_wdata;

   // Helpers.
   logic           port_hit;
   logic           proc_issue;
   logic           port_issue;
   logic           done_ok;
   logic [QW-1:0]  tail_nxt;
   logic [QW-1:0]  head_nxt;
   logic [PW-1:0]  cur_nxt;

   assign tail_nxt = (ftail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : ftail_ff + 1'b1;
   assign head_nxt = (fhead_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : fhead_ff + 1'b1;
   assign cur_nxt  = (cur_ff == PW'(NUM_PROCS - 1)) ? '0 : cur_ff + 1'b1;
   assign done_ok  = !rsp_valid_ff || !rsp_stall;
   assign port_issue = (scan_ff < (PIW+1)'(NUM_PORTS));
   assign proc_issue = (sch_cnt_ff < (PW+1)'(NUM_PROCS));

   always_comb begin
      unique case (op_ff)
         OP_SEND:   port_hit = (prd_ident_ff == pid_ff);
         OP_RECV:   port_hit = (prd_ident_ff == pid_ff) && (prd_owner_ff == cur_ff);
         default:   port_hit = (prd_owner_ff == '0);
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_CLEAR: begin
            if (clr_ff == PW'(NUM_PROCS - 1)) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_IDLE: begin
            if (req_valid) begin
               unique case (req_data.op)
                  OP_SEND, OP_RECV:
                     state_in = (req_data.port_id == '0) ? SEQ_DONE : SEQ_PSCAN;
                  OP_CREATE: state_in = SEQ_PSCAN;
                  OP_YIELD:  state_in = SEQ_SSCAN;
                  OP_TICK:   state_in = SEQ_PRD;
                  default:   state_in = SEQ_DONE;
               endcase
            end
         end
         SEQ_PSCAN: begin
            if (prd_ok_ff && port_hit) begin
               state_in = SEQ_PEVAL;
            end else if (prd_ok_ff && prd_last_ff) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_PEVAL: begin
            unique case (op_ff)
               OP_SEND:
                  state_in = (tail_nxt == fhead_ff) ? SEQ_DONE : SEQ_PRD;
               OP_RECV: begin
                  if (fhead_ff != ftail_ff) begin
                     state_in = SEQ_QRD;
                  end else begin
                     state_in = blk_ff ? SEQ_SSCAN : SEQ_DONE;
                  end
               end
               default: state_in = SEQ_DONE;
            endcase
         end
         SEQ_QRD:  state_in = SEQ_DONE;
         SEQ_PRD:  state_in = SEQ_PCHK;
         SEQ_PCHK: state_in = (op_ff == OP_SEND) ? SEQ_DONE : SEQ_SSCAN;
         SEQ_SSCAN: begin
            if (srd_ok_ff && ((ps_rd_ff == PS_READY) || srd_last_ff)) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (done_ok) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_in       = clr_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      hdl_in       = hdl_ff;
      blk_in       = blk_ff;
      cur_in       = cur_ff;
      nid_in       = nid_ff;
      scan_in      = scan_ff;
      prd_ok_in    = 1'b0;
      prd_last_in  = 1'b0;
      prd_idx_in   = scan_ff[PIW-1:0];
      fidx_in      = fidx_ff;
      fowner_in    = fowner_ff;
      fhead_in     = fhead_ff;
      ftail_in     = ftail_ff;
      sch_addr_in  = sch_addr_ff;
      sch_cnt_in   = sch_cnt_ff;
      srd_ok_in    = 1'b0;
      srd_last_in  = 1'b0;
      srd_idx_in   = sch_addr_ff;
      res_sts_in   = res_sts_ff;
      res_nid_in   = res_nid_ff;
      res_msg_in   = res_msg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      req_stall    = 1'b1;

      port_raddr      = scan_ff[PIW-1:0];
      port_waddr      = fidx_ff;
      port_create     = 1'b0;
      head_we         = 1'b0;
      tail_we         = 1'b0;
      queue_ptr_wdata = tail_nxt;
      q_addr          = QAW'(fidx_ff) * QAW'(QUEUE_DEPTH) + QAW'(ftail_ff);
      q_we            = 1'b0;
      proc_raddr      = sch_addr_ff;
      ps_waddr        = cur_ff;
      ps_we           = 1'b0;
      ps_wdata        = PS_READY;
      pw_we           = 1'b0;
      pw_waddr        = cur_ff;
      pw_wdata        = pid_ff;

      unique case (state_ff)
         SEQ_CLEAR: begin
            // Pid 0 comes out of reset running and every other process ready.
            clr_in   = clr_ff + 1'b1;
            ps_we    = 1'b1;
            ps_waddr = clr_ff;
            ps_wdata = (clr_ff == '0) ? PS_RUNNING : PS_READY;
            pw_we    = 1'b1;
            pw_waddr = clr_ff;
            pw_wdata = '0;
         end
         SEQ_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in       = req_data.op;
               pid_in      = req_data.port_id;
               hdl_in      = req_data.msg_handle;
               blk_in      = req_data.blocking;
               res_sts_in  = STS_OK;
               res_nid_in  = '0;
               res_msg_in  = '0;
               scan_in     = '0;
               sch_addr_in = cur_nxt;
               sch_cnt_in  = '0;
               unique case (req_data.op)
                  OP_SEND, OP_RECV: begin
                     if (req_data.port_id == '0) begin
                        res_sts_in = STS_NOPORT;
                     end
                  end
                  OP_CREATE: ;
                  OP_YIELD: begin
                     ps_we    = 1'b1;
                     ps_wdata = PS_READY;
                  end
                  OP_TICK: ;
                  default: res_sts_in = STS_BADOP;
               endcase
            end
         end
         SEQ_PSCAN: begin
            if (port_issue) begin
               prd_ok_in   = 1'b1;
               prd_last_in = (scan_ff == (PIW+1)'(NUM_PORTS - 1));
               scan_in     = scan_ff + 1'b1;
            end
            if (prd_ok_ff && port_hit) begin
               fidx_in   = prd_idx_ff;
               fowner_in = prd_owner_ff;
               fhead_in  = prd_head_ff;
               ftail_in  = prd_tail_ff;
            end else if (prd_ok_ff && prd_last_ff) begin
               res_sts_in = (op_ff == OP_CREATE) ? STS_NOFREE : STS_NOPORT;
            end
         end
         SEQ_PEVAL: begin
            unique case (op_ff)
               OP_SEND: begin
                  if (tail_nxt == fhead_ff) begin
                     res_sts_in = STS_FULL;
                  end else begin
                     q_we    = 1'b1;
                     tail_we = 1'b1;
                  end
               end
               OP_RECV: begin
                  if (fhead_ff != ftail_ff) begin
                     q_addr          = QAW'(fidx_ff) * QAW'(QUEUE_DEPTH) + QAW'(fhead_ff);
                     head_we         = 1'b1;
                     queue_ptr_wdata = head_nxt;
                  end else if (!blk_ff) begin
                     res_sts_in = STS_EMPTY;
                  end else begin
                     ps_we      = 1'b1;
                     ps_wdata   = PS_BLOCKED;
                     pw_we      = 1'b1;
                     res_sts_in = STS_BLOCKED;
                  end
               end
               default: begin
                  port_create = 1'b1;
                  res_nid_in  = nid_ff;
                  nid_in      = (nid_ff == 32'hFFFF_FFFF) ? 32'd1 : nid_ff + 32'd1;
               end
            endcase
         end
         SEQ_QRD: begin
            res_msg_in = q_rd_ff;
         end
         SEQ_PRD: begin
            proc_raddr = (op_ff == OP_SEND) ? fowner_ff : cur_ff;
         end
         SEQ_PCHK: begin
            if (op_ff == OP_SEND) begin
               // Wake the owner only if it sleeps on some port.
               if ((ps_rd_ff == PS_BLOCKED) && (pw_rd_ff != '0)) begin
                  ps_we    = 1'b1;
                  ps_waddr = fowner_ff;
                  ps_wdata = PS_READY;
               end
            end else if (ps_rd_ff == PS_RUNNING) begin
               ps_we    = 1'b1;
               ps_wdata = PS_READY;
            end
         end
         SEQ_SSCAN: begin
            // Reads stream from cur+1 around to cur itself; each read's data shows in the cycle after.
            if (proc_issue) begin
               srd_ok_in   = 1'b1;
               srd_last_in = (sch_cnt_ff == (PW+1)'(NUM_PROCS - 1));
               sch_cnt_in  = sch_cnt_ff + 1'b1;
               sch_addr_in = (sch_addr_ff == PW'(NUM_PROCS - 1)) ? '0 : sch_addr_ff + 1'b1;
            end
            if (srd_ok_ff && (ps_rd_ff == PS_READY)) begin
               cur_in   = srd_idx_ff;
               ps_we    = 1'b1;
               ps_waddr = srd_idx_ff;
               ps_wdata = PS_RUNNING;
            end else if (srd_ok_ff && srd_last_ff) begin
               res_sts_in = STS_IDLE;
            end
         end
         SEQ_DONE: begin
            if (done_ok) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = res_sts_ff;
               rsp_data_in.new_port_id = res_nid_ff;
               rsp_data_in.msg_out     = res_msg_ff;
               rsp_data_in.running_pid = 8'(cur_ff);
            end
         end
         default: ;
      endcase
   end

   // Control registers and valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_CLEAR;
         clr_ff        <= '0;
         cur_ff        <= '0;
         nid_ff        <= 32'd1;
         prd_ok_ff     <= 1'b0;
         srd_ok_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         port_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         nid_ff       <= nid_in;
         prd_ok_ff    <= prd_ok_in;
         srd_ok_ff    <= srd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (port_create) begin
            port_vld_ff[port_waddr] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pid_ff      <= pid_in;
      hdl_ff      <= hdl_in;
      blk_ff      <= blk_in;
      scan_ff     <= scan_in;
      prd_last_ff <= prd_last_in;
      prd_idx_ff  <= prd_idx_in;
      fidx_ff     <= fidx_in;
      fowner_ff   <= fowner_in;
      fhead_ff    <= fhead_in;
      ftail_ff    <= ftail_in;
      sch_addr_ff <= sch_addr_in;
      sch_cnt_ff  <= sch_cnt_in;
      srd_last_ff <= srd_last_in;
      srd_idx_ff  <= srd_idx_in;
      res_sts_ff  <= res_sts_in;
      res_nid_ff  <= res_nid_in;
      res_msg_ff  <= res_msg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Port table. An entry that was never created reads as all zero.
   always_ff @(posedge clock) begin
      if (port_create) begin
         owner_mem[port_waddr] <= cur_ff;
         ident_mem[port_waddr] <= nid_ff;
      end
      if (port_create || head_we) begin
         head_mem[port_waddr] <= port_create ? '0 : queue_ptr_wdata;
      end
      if (port_create || tail_we) begin
         tail_mem[port_waddr] <= port_create ? '0 : queue_ptr_wdata;
      end
      if (port_vld_ff[port_raddr]) begin
         prd_owner_ff <= owner_mem[port_raddr];
         prd_ident_ff <= ident_mem[port_raddr];
         prd_head_ff  <= head_mem[port_raddr];
         prd_tail_ff  <= tail_mem[port_raddr];
      end else begin
         prd_owner_ff <= '0;
         prd_ident_ff <= '0;
         prd_head_ff  <= '0;
         prd_tail_ff  <= '0;
      end
   end

   // Message rings.
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_addr] <= hdl_ff;
      end
      q_rd_ff <= queue_mem[q_addr];
   end

   // Process table, filled by the clearing pass after reset.
   always_ff @(posedge clock) begin
      if (ps_we) begin
         pstate_mem[ps_waddr] <= ps_wdata;
      end
      if (pw_we) begin
         pwait_mem[pw_waddr] <= pw_wdata;
      end
      ps_rd_ff <= pstate_mem[proc_raddr];
      pw_rd_ff <= pwait_mem[proc_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the IPC port mailbox and process scheduler.
module testbench;
   import ipcmb_pkg::*;

   localparam int NPORT   = DEF_NUM_PORTS;
   localparam int NPROC   = DEF_NUM_PROCS;
   localparam int N_RAND  = 1700;
   localparam int WDOG    = 30000;
   localparam logic [2:0] OP_BAD5 = 3'd5;
   localparam logic [2:0] OP_BAD6 = 3'd6;
   localparam logic [2:0] OP_BAD7 = 3'd7;

   typedef struct packed {
      req_type rq;
      logic    known;
      rsp_type ex;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Mirror of the block's tables.
   logic [7:0]  m_owner [NPORT];
   logic [31:0] m_ident [NPORT];
   logic [31:0] m_ring  [NPORT][32];
   logic [4:0]  m_head  [NPORT];
   logic [4:0]  m_tail  [NPORT];
   logic [1:0]  m_pstate[NPROC];
   logic [31:0] m_waitp [NPROC];
   logic [7:0]  m_cur;
   logic [31:0] m_next_id;
   logic [31:0] hot_id;

   rsp_type pending_rsp[$];
   int      errors = 0;
   int      stall_pct = 0;
   int      gap_pct = 0;
   int      quiet = 0;

   dir_row_type dir_rows[] = '{
      '{'{OP_BAD5, 32'd0, 32'd0, 1'b0}, 1'b1, '{STS_BADOP, 32'd0, 32'd0, 8'd0}},
      '{'{OP_BAD7, '1, '1, 1'b1}, 1'b1, '{STS_BADOP, 32'd0, 32'd0, 8'd0}},
      '{'{OP_SEND, 32'd0, 32'h1234, 1'b0}, 1'b1, '{STS_NOPORT, 32'd0, 32'd0, 8'd0}},
      '{'{OP_RECV, 32'd0, 32'd0, 1'b1}, 1'b1, '{STS_NOPORT, 32'd0, 32'd0, 8'd0}},
      '{'{OP_CREATE, 32'd0, 32'd0, 1'b0}, 1'b1, '{STS_OK, 32'd1, 32'd0, 8'd0}},
      '{'{OP_SEND, 32'd1, '1, 1'b0}, 1'b1, '{STS_OK, 32'd0, 32'd0, 8'd0}},
      '{'{OP_RECV, 32'd1, 32'd0, 1'b0}, 1'b1, '{STS_OK, 32'd0, '1, 8'd0}},
      '{'{OP_RECV, 32'd1, 32'd0, 1'b0}, 1'b1, '{STS_EMPTY, 32'd0, 32'd0, 8'd0}},
      '{'{OP_SEND, '1, 32'd0, 1'b0}, 1'b1, '{STS_NOPORT, 32'd0, 32'd0, 8'd0}},
      '{'{OP_BAD6, 32'd5, 32'd6, 1'b0}, 1'b1, '{STS_BADOP, 32'd0, 32'd0, 8'd0}},
      '{'{OP_YIELD, 32'd0, 32'd0, 1'b0}, 1'b1, '{STS_OK, 32'd0, 32'd0, 8'd1}},
      // Port 0 still counts as free because pid 0 created it.
      '{'{OP_CREATE, 32'd0, 32'd0, 1'b0}, 1'b1, '{STS_OK, 32'd2, 32'd0, 8'd1}},
      '{'{OP_RECV, 32'd2, 32'd0, 1'b1}, 1'b1, '{STS_BLOCKED, 32'd0, 32'd0, 8'd2}},
      '{'{OP_SEND, 32'd2, 32'h5A5A_A5A5, 1'b0}, 1'b0, '0},
      '{'{OP_TICK, 32'd0, 32'd0, 1'b0}, 1'b0, '0},
      '{'{OP_RECV, 32'd1, 32'd0, 1'b1}, 1'b0, '0},
      '{'{OP_CREATE, 32'd0, 32'd0, 1'b0}, 1'b0, '0},
      '{'{OP_RECV, 32'd3, 32'd0, 1'b0}, 1'b0, '0},
      '{'{OP_RECV, 32'd3, 32'd0, 1'b1}, 1'b0, '0},
      '{'{OP_SEND, 32'd3, 32'h8000_0001, 1'b0}, 1'b0, '0},
      '{'{OP_TICK, 32'd0, 32'd0, 1'b0}, 1'b0, '0},
      '{'{OP_YIELD, 32'd0, 32'd0, 1'b0}, 1'b0, '0}
   };

   ipc_port_mailbox_scheduler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   function automatic bit switch_proc();
      logic [7:0] p;
      p = m_cur + 8'd1;
      while (p != m_cur && m_pstate[p] != PS_READY) p = p + 8'd1;
      if (p == m_cur && m_pstate[p] != PS_READY) return 1'b0;
      m_cur = p;
      m_pstate[p] = PS_RUNNING;
      return 1'b1;
   endfunction

   function automatic int lookup_port(logic [31:0] id, bit owned);
      if (id == 32'd0) return NPORT;
      for (int i = 0; i < NPORT; i++)
         if (m_ident[i] == id && (!owned || m_owner[i] == m_cur)) return i;
      return NPORT;
   endfunction

   function automatic rsp_type mailbox_step(req_type rq);
      rsp_type r;
      int p;
      logic [7:0] own;
      r = '0;
      case (rq.op)
         OP_SEND: begin
            p = lookup_port(rq.port_id, 1'b0);
            if (p == NPORT) r.status = STS_NOPORT;
            else if (m_tail[p] + 5'd1 == m_head[p]) r.status = STS_FULL;
            else begin
               m_ring[p][m_tail[p]] = rq.msg_handle;
               m_tail[p] = m_tail[p] + 5'd1;
               own = m_owner[p];
               if (m_pstate[own] == PS_BLOCKED && m_waitp[own] != 32'd0)
                  m_pstate[own] = PS_READY;
            end
         end
         OP_RECV: begin
            p = lookup_port(rq.port_id, 1'b1);
            if (p == NPORT) r.status = STS_NOPORT;
            else if (m_head[p] == m_tail[p]) begin
               if (!rq.blocking) r.status = STS_EMPTY;
               else begin
                  m_pstate[m_cur] = PS_BLOCKED;
                  m_waitp[m_cur] = rq.port_id;
                  r.status = switch_proc() ? STS_BLOCKED : STS_IDLE;
               end
            end else begin
               r.msg_out = m_ring[p][m_head[p]];
               m_head[p] = m_head[p] + 5'd1;
            end
         end
         OP_CREATE: begin
            p = 0;
            while (p < NPORT && m_owner[p] != 8'd0) p++;
            if (p == NPORT) r.status = STS_NOFREE;
            else begin
               m_owner[p] = m_cur;
               m_ident[p] = m_next_id;
               m_head[p] = '0;
               m_tail[p] = '0;
               r.new_port_id = m_next_id;
               hot_id = m_next_id;
               m_next_id = m_next_id + 32'd1;
               if (m_next_id == 32'd0) m_next_id = 32'd1;
            end
         end
         OP_YIELD: begin
            m_pstate[m_cur] = PS_READY;
            if (!switch_proc()) r.status = STS_IDLE;
         end
         OP_TICK: begin
            if (m_pstate[m_cur] == PS_RUNNING) m_pstate[m_cur] = PS_READY;
            if (!switch_proc()) r.status = STS_IDLE;
         end
         default: r.status = STS_BADOP;
      endcase
      r.running_pid = m_cur;
      return r;
   endfunction

   function automatic logic [31:0] pick_id();
      int k;
      k = $urandom_range(99);
      if (k < 40) return hot_id;
      if (k < 85) return $urandom_range(m_next_id - 1, (m_next_id > 70) ? m_next_id - 70 : 1);
      if (k < 93) return 32'd0;
      return $urandom;
   endfunction

   function automatic req_type random_request();
      req_type rq;
      int k;
      int owned[$];
      rq.msg_handle = $urandom;
      rq.blocking = $urandom_range(1);
      rq.port_id = pick_id();
      k = $urandom_range(99);
      if (k < 38) rq.op = OP_SEND;
      else if (k < 62) begin
         rq.op = OP_RECV;
         for (int i = 0; i < NPORT; i++)
            if (m_ident[i] != 32'd0 && m_owner[i] == m_cur) owned.push_back(i);
         if (owned.size() > 0 && $urandom_range(9) < 8)
            rq.port_id = m_ident[owned[$urandom_range(owned.size() - 1)]];
      end
      else if (k < 72) rq.op = OP_CREATE;
      else if (k < 83) rq.op = OP_YIELD;
      else if (k < 95) rq.op = OP_TICK;
      else rq.op = 3'($urandom_range(7, 5));
      return rq;
   endfunction

   // Presents one request and waits for it to be taken.
   task automatic issue(req_type rq, bit known, rsp_type ex);
      rsp_type pr;
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = rq;
      do @(posedge clock); while (req_stall);
      pr = mailbox_step(rq);
      pending_rsp.push_back(known ? ex : pr);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      rsp_type ex;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            ex = pending_rsp.pop_front();
            if (rsp_data.status !== ex.status || rsp_data.new_port_id !== ex.new_port_id ||
                rsp_data.msg_out !== ex.msg_out || rsp_data.running_pid !== ex.running_pid)
            begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p, got %p", ex, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NPORT; i++) begin
         m_owner[i] = '0;
         m_ident[i] = '0;
         m_head[i] = '0;
         m_tail[i] = '0;
      end
      for (int i = 0; i < NPROC; i++) begin
         m_pstate[i] = PS_READY;
         m_waitp[i] = '0;
      end
      m_pstate[0] = PS_RUNNING;
      m_cur = '0;
      m_next_id = 32'd1;
      hot_id = 32'd1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      gap_pct = 9;
      stall_pct = 87;
      foreach (dir_rows[i]) issue(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].ex);
      for (int n = 0; n < N_RAND; n++) begin
         if (n == N_RAND / 3) begin
            gap_pct = 87;
            stall_pct = 9;
         end else if (n == 2 * N_RAND / 3) begin
            gap_pct = 0;
            stall_pct = 0;
         end
         issue(random_request(), 1'b0, '0);
      end
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
